// ===== rtl/srrip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_pkg
// Shared types and constants of the 2-bit SRRIP victim selection core.
// ----------------------------------------------------------------------------
package srrip_pkg;

  localparam int DEFAULT_SETS = 64;
  localparam int DEFAULT_WAYS = 16;

  // the eligibility mask only reaches ways 0..15
  localparam int MASK_BITS = 16;

  localparam logic [1:0] RRPV_MAX    = 2'd3;
  localparam logic [1:0] RRPV_INSERT = 2'd2;
  localparam logic [1:0] RRPV_HIT    = 2'd0;

  typedef enum logic [1:0] {
    REQ_HIT    = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_SELECT = 2'd2,
    REQ_PEEK   = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [5:0]  set_index;
    logic [3:0]  way_index;
    logic [15:0] eligible_mask;
  } req_item_t;

  typedef struct packed {
    logic       victim_found;
    logic [3:0] victim_way;
  } rsp_item_t;

  // status of one row update
  typedef struct packed {
    logic wr;       // row must be written back
    logic has_rsp;  // item produces a result
  } upd_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/srrip_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module srrip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/srrip_row_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_row_update
// Modify step of the set read-modify-write: hit/insert update, victim
// search over the eligible ways and aging of the whole set.
// ----------------------------------------------------------------------------
module srrip_row_update #(
  parameter int WAYS = srrip_pkg::DEFAULT_WAYS
) (
  input  wire srrip_pkg::req_item_t req,
  input  wire logic                 set_ok,
  input  wire logic [2*WAYS-1:0]    row_in,
  output logic      [2*WAYS-1:0]    row_out,
  output srrip_pkg::upd_ctl_t       ctl,
  output srrip_pkg::rsp_item_t      rsp
);

  logic [1:0]      val [WAYS];
  logic [WAYS-1:0] elig;
  logic [WAYS-1:0] at3;
  logic [WAYS-1:0] at2;
  logic [WAYS-1:0] at1;
  logic [WAYS-1:0] match;
  logic [1:0]      top;
  logic [1:0]      delta;
  logic [3:0]      pick;
  logic            way_ok;
  logic [2*WAYS-1:0] touched_row;
  logic [2*WAYS-1:0] aged_row;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign val[w] = row_in[2*w +: 2];
    if (w < srrip_pkg::MASK_BITS) begin : g_mask
      assign elig[w] = req.eligible_mask[w];
    end else begin : g_nomask
      assign elig[w] = 1'b0;
    end
    assign at3[w]   = elig[w] && (val[w] == 2'd3);
    assign at2[w]   = elig[w] && (val[w] == 2'd2);
    assign at1[w]   = elig[w] && (val[w] == 2'd1);
    assign match[w] = elig[w] && (val[w] == top);
  end

  always_comb begin
    if (|at3) begin
      top = 2'd3;
    end else if (|at2) begin
      top = 2'd2;
    end else if (|at1) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    delta = srrip_pkg::RRPV_MAX - top;
  end

  // lowest-numbered eligible way holding the largest value
  always_comb begin
    pick = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        pick = 4'(w);
      end
    end
  end

  always_comb begin
    logic [2:0] sum;
    for (int w = 0; w < WAYS; w++) begin
      sum = {1'b0, val[w]} + {1'b0, delta};
      aged_row[2*w +: 2] = sum[2] ? srrip_pkg::RRPV_MAX : sum[1:0];
    end
  end

  assign way_ok = 32'(req.way_index) < 32'(WAYS);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (32'(req.way_index) == 32'(w)) begin
        touched_row[2*w +: 2] = (req.req_type == srrip_pkg::REQ_HIT) ?
                                srrip_pkg::RRPV_HIT : srrip_pkg::RRPV_INSERT;
      end else begin
        touched_row[2*w +: 2] = row_in[2*w +: 2];
      end
    end
  end

  always_comb begin
    row_out          = row_in;
    ctl              = '0;
    rsp              = '0;
    rsp.victim_found = set_ok && (|elig);
    rsp.victim_way   = (set_ok && (|elig)) ? pick : 4'd0;
    case (req.req_type)
      srrip_pkg::REQ_HIT, srrip_pkg::REQ_INSERT: begin
        row_out = touched_row;
        ctl.wr  = set_ok && way_ok;
        rsp     = '0;
      end
      srrip_pkg::REQ_SELECT: begin
        row_out     = aged_row;
        ctl.wr      = rsp.victim_found;
        ctl.has_rsp = 1'b1;
      end
      srrip_pkg::REQ_PEEK: begin
        ctl.has_rsp = 1'b1;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/srrip_victim_selection_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_victim_selection_core
// SRRIP replacement state with hit, insert, select-with-aging and peek.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall/req_data, results leave on
//   rsp_valid/rsp_stall/rsp_data; an item moves when valid is high and
//   stall is low. Hit and insert produce no result; select and peek produce
//   exactly one, in request order.
//   The per-set RRPV rows live in one RAM. An accepted request reads its
//   row at the accept edge; the modify stage then updates it, writes it back
//   and loads the result register, which drives rsp_valid. One request per
//   cycle is sustained unless a result is held under rsp_stall; a request to
//   the set being written in the same cycle sees the new row through the RAM
//   bypass. After reset the RAM is swept to all-3 values, one set per cycle;
//   req_stall stays high until the sweep ends.
//   While a result waits under rsp_stall, one more request may be held in
//   the modify stage; hit and insert still pass through it.
// ----------------------------------------------------------------------------
module srrip_victim_selection_core #(
  parameter int SETS = srrip_pkg::DEFAULT_SETS,
  parameter int WAYS = srrip_pkg::DEFAULT_WAYS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire srrip_pkg::req_item_t req_data,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output srrip_pkg::rsp_item_t      rsp_data
);

  localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W = 2 * WAYS;

  logic                 clearing;
  logic [AW-1:0]        clear_addr;
  logic                 accept;

  logic                 s1_valid;
  srrip_pkg::req_item_t s1_item;
  logic                 s1_set_ok;
  logic                 s1_advance;
  logic                 s1_fire;

  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     upd_row;
  srrip_pkg::upd_ctl_t  upd_ctl;
  srrip_pkg::rsp_item_t upd_rsp;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;

  // modify stage may move unless it owes a result to a blocked output
  assign s1_advance = !upd_ctl.has_rsp || !rsp_valid || !rsp_stall;
  assign s1_fire    = s1_valid && s1_advance;
  assign req_stall  = clearing || (s1_valid && !s1_advance);
  assign accept     = req_valid && !req_stall;
  assign s1_set_ok  = 32'(s1_item.set_index) < 32'(SETS);

  assign ram_we    = clearing || (s1_fire && upd_ctl.wr);
  assign ram_waddr = clearing ? clear_addr : AW'(s1_item.set_index);
  assign ram_wdata = clearing ? {WAYS{srrip_pkg::RRPV_MAX}} : upd_row;

  srrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_rrpv_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(req_data.set_index)),
    .rdata (rd_row)
  );

  srrip_row_update #(
    .WAYS (WAYS)
  ) u_row_update (
    .req     (s1_item),
    .set_ok  (s1_set_ok),
    .row_in  (rd_row),
    .row_out (upd_row),
    .ctl     (upd_ctl),
    .rsp     (upd_rsp)
  );

  // reset sweep of the RRPV RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(SETS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire && upd_ctl.has_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && upd_ctl.has_rsp) begin
      rsp_data <= upd_rsp;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_srrip_victim_selection_core.sv =====
// ----------------------------------------------------------------------------
// tb_srrip_victim_selection_core
// Self-checking bench: a local SRRIP table model predicts every victim result.
// The bench sends hit, insert, select and peek requests with random idle gaps
// and result-side stalls, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_srrip_victim_selection_core;

  localparam int NSETS      = srrip_pkg::DEFAULT_SETS;
  localparam int NWAYS      = srrip_pkg::DEFAULT_WAYS;
  localparam int IDLE_LIMIT = 2000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  srrip_pkg::req_item_t req_data  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  srrip_pkg::rsp_item_t rsp_data;

  // local copy of the per-set RRPV rows, way w in bits 2w+1..2w
  logic [2*NWAYS-1:0]   rrpv_model [NSETS];
  srrip_pkg::rsp_item_t victim_expect [$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int reqs_sent = 0;
  int victims_checked = 0;
  int victims_found = 0;

  srrip_victim_selection_core #(
    .SETS(NSETS),
    .WAYS(NWAYS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  always #1 clk = ~clk;

  // mostly zero, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic srrip_pkg::req_item_t mk_req(input srrip_pkg::req_type_t t,
                                                  input int s, input int w,
                                                  input logic [15:0] m);
    srrip_pkg::req_item_t r;
    r.req_type      = t;
    r.set_index     = s[5:0];
    r.way_index     = w[3:0];
    r.eligible_mask = m;
    return r;
  endfunction

  // update the model table for one request; select and peek yield a result
  function automatic void rrpv_apply(input srrip_pkg::req_item_t r, output bit has_rsp,
                                     output srrip_pkg::rsp_item_t rsp);
    logic [2*NWAYS-1:0] row;
    int top, delta, v, pick;
    bit any;
    has_rsp = 1'b0;
    rsp     = '0;
    any     = 1'b0;
    top     = 0;
    pick    = 0;
    if (r.req_type == srrip_pkg::REQ_HIT || r.req_type == srrip_pkg::REQ_INSERT) begin
      if (r.set_index < NSETS && r.way_index < NWAYS)
        rrpv_model[r.set_index][2*r.way_index +: 2] =
          (r.req_type == srrip_pkg::REQ_HIT) ? srrip_pkg::RRPV_HIT : srrip_pkg::RRPV_INSERT;
      return;
    end
    has_rsp = 1'b1;
    if (r.set_index >= NSETS) return;
    row = rrpv_model[r.set_index];
    for (int w = 0; w < NWAYS; w++) begin
      if (w < srrip_pkg::MASK_BITS && r.eligible_mask[w]) begin
        v = row[2*w +: 2];
        if (!any || v > top) begin
          top  = v;
          pick = w;
        end
        any = 1'b1;
      end
    end
    if (!any) return;
    // age the whole set so that the oldest eligible way reaches the maximum
    delta = srrip_pkg::RRPV_MAX - top;
    for (int w = 0; w < NWAYS; w++) begin
      v = row[2*w +: 2] + delta;
      if (v > srrip_pkg::RRPV_MAX) v = srrip_pkg::RRPV_MAX;
      row[2*w +: 2] = v[1:0];
    end
    if (r.req_type == srrip_pkg::REQ_SELECT) rrpv_model[r.set_index] = row;
    rsp.victim_found = 1'b1;
    rsp.victim_way   = pick[3:0];
  endfunction

  // most requests land in a few hot sets so hits, inserts and selects interact
  function automatic srrip_pkg::req_item_t make_rand_req(input int hot_sets);
    srrip_pkg::req_item_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)      r.req_type = srrip_pkg::REQ_HIT;
    else if (pick < 58) r.req_type = srrip_pkg::REQ_INSERT;
    else if (pick < 85) r.req_type = srrip_pkg::REQ_SELECT;
    else                r.req_type = srrip_pkg::REQ_PEEK;
    if ($urandom_range(9) < 8) r.set_index = 6'($urandom_range(hot_sets - 1));
    else                       r.set_index = 6'($urandom_range(NSETS - 1));
    r.way_index = 4'($urandom_range(NWAYS - 1));
    case ($urandom_range(9))
      0:       r.eligible_mask = '0;
      1:       r.eligible_mask = '1;
      2, 3:    r.eligible_mask = 16'h1 << $urandom_range(srrip_pkg::MASK_BITS - 1);
      default: r.eligible_mask = 16'($urandom_range(16'hFFFF));
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // valid stays high across back-to-back items; it drops only for a gap
  task automatic send_item(input srrip_pkg::req_item_t r);
    int gap;
    bit has_rsp;
    srrip_pkg::rsp_item_t exp_rsp;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    reqs_sent++;
    rrpv_apply(r, has_rsp, exp_rsp);
    if (has_rsp) victim_expect = {victim_expect, exp_rsp};
  endtask

  task automatic test_fresh_sets();
    send_item(mk_req(srrip_pkg::REQ_PEEK, 0, 0, 16'hFFFF));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 63, 15, 16'h8000));
    send_item(mk_req(srrip_pkg::REQ_SELECT, 63, 0, 16'h0000));  // nothing eligible
    send_item(mk_req(srrip_pkg::REQ_PEEK, 17, 9, 16'h0000));
  endtask

  task automatic test_hit_insert();
    send_item(mk_req(srrip_pkg::REQ_HIT, 5, 0, 16'h0000));
    send_item(mk_req(srrip_pkg::REQ_INSERT, 5, 15, 16'hFFFF));
    send_item(mk_req(srrip_pkg::REQ_HIT, 5, 3, 16'h0000));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 5, 0, 16'hFFFF));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 5, 0, 16'h8009));
    // all eligible at 0: full aging
    send_item(mk_req(srrip_pkg::REQ_SELECT, 5, 0, 16'h0009));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 5, 0, 16'h0008));
  endtask

  task automatic test_aging();
    send_item(mk_req(srrip_pkg::REQ_INSERT, 40, 7, 16'h0000));
    send_item(mk_req(srrip_pkg::REQ_HIT, 40, 2, 16'h0000));
    send_item(mk_req(srrip_pkg::REQ_SELECT, 40, 0, 16'h0080));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 40, 0, 16'h0004));
    send_item(mk_req(srrip_pkg::REQ_SELECT, 40, 0, 16'h0004));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 40, 0, 16'hFFFF));
    send_item(mk_req(srrip_pkg::REQ_INSERT, 63, 15, 16'h0000));
    send_item(mk_req(srrip_pkg::REQ_HIT, 63, 15, 16'h0000));
    send_item(mk_req(srrip_pkg::REQ_SELECT, 63, 15, 16'h8000));
    send_item(mk_req(srrip_pkg::REQ_PEEK, 63, 0, 16'hFFFF));
  endtask

  task automatic test_random_idle(input int n);
    idle_on = 1'b1;
    for (int i = 0; i < n; i++) send_item(make_rand_req(4));
  endtask

  // back-to-back on two sets exercises the write-back forwarding path
  task automatic test_random_back_to_back(input int n);
    idle_on = 1'b0;
    for (int i = 0; i < n; i++) send_item(make_rand_req(2));
    idle_on = 1'b1;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (victim_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result side stall
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(3) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    srrip_pkg::rsp_item_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      victims_checked++;
      if (victim_expect.size() == 0) begin
        report_mismatch("unexpected result, victim_way", -1, rsp_data.victim_way);
      end else begin
        exp_rsp = victim_expect.pop_front();
        if (exp_rsp.victim_found) victims_found++;
        if (rsp_data.victim_found !== exp_rsp.victim_found)
          report_mismatch("victim_found", exp_rsp.victim_found, rsp_data.victim_found);
        if (rsp_data.victim_way !== exp_rsp.victim_way)
          report_mismatch("victim_way", exp_rsp.victim_way, rsp_data.victim_way);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("tb_srrip_victim_selection_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < NSETS; s++) rrpv_model[s] = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_fresh_sets();
    test_hit_insert();
    test_aging();
    test_random_idle(1100);
    test_random_back_to_back(650);
    drain();
    $display("covered %0d requests (hit, insert, select, peek) with idle gaps and stalls",
             reqs_sent);
    $display("checked %0d victim results, %0d with a victim found, %0d mismatches",
             victims_checked, victims_found, errors);
    if (errors == 0) begin
      $display("tb_srrip_victim_selection_core: clean");
    end else begin
      $display("tb_srrip_victim_selection_core: errors");
    end
    $finish;
  end

endmodule
